// ===== design/wsdg_pkg.sv =====
`timescale 1ns / 1ps
package wsdg_pkg;

	// Window and sample geometry
	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_W     = 12;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
	localparam int SUM_W        = SAMPLE_W + WIN_AW;
	localparam int SQ_W         = 2 * SAMPLE_W;
	localparam int SQSUM_W      = SQ_W + WIN_AW;
	localparam int DEV_W        = 2 * SUM_W;
	localparam int ROOT_W       = SUM_W;
	localparam int REM_W        = ROOT_W + 2;

	// Spread in whole ms: root / (16 * N), always below 256
	localparam int SPREAD_DIV   = 16 * WINDOW_DEPTH;
	localparam int SPREAD_W     = SAMPLE_W - 4;

	// Result fields
	localparam int LEVEL_W      = 4;
	localparam int COLOUR_W     = 8;
	localparam logic [COLOUR_W-1:0] COLOUR_FULL = 8'd255;
	localparam logic [COLOUR_W-1:0] COLOUR_NONE = 8'd0;

	// Shared divider: 510 * 4095 fits in 21 bits, divisor up to 12 bits
	localparam int HUE_SCALE    = 510;
	localparam int DIVD_W       = SAMPLE_W + 9;
	localparam int DIVS_W       = SAMPLE_W;

	// Register file
	localparam int REG_COUNT    = 4;
	localparam int ADDR_W       = $clog2(REG_COUNT * 4);
	localparam int DATA_W       = 32;

	typedef enum logic [1:0] {
		REG_LOW_BOUND,
		REG_HIGH_BOUND,
		REG_SPREAD_CEILING,
		REG_LEVEL_COUNT
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] LOW_BOUND_RST      = 12'd320;
	localparam logic [SAMPLE_W-1:0] HIGH_BOUND_RST     = 12'd1600;
	localparam logic [SPREAD_W-1:0] SPREAD_CEILING_RST = 8'd50;
	localparam logic [LEVEL_W-1:0]  LEVEL_COUNT_RST    = 4'd6;

	typedef struct packed {
		logic [SAMPLE_W-1:0] low_bound;
		logic [SAMPLE_W-1:0] high_bound;
		logic [SPREAD_W-1:0] spread_ceiling;
		logic [LEVEL_W-1:0]  level_count;
	} cfg_t;

endpackage

// ===== design/wsdg_in_if.sv =====
`timescale 1ns / 1ps
interface wsdg_in_if;
	import wsdg_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] hrv_sample;

	modport source (output valid, output hrv_sample, input ready);
	modport sink (input valid, input hrv_sample, output ready);
endinterface

// ===== design/wsdg_out_if.sv =====
`timescale 1ns / 1ps
interface wsdg_out_if;
	import wsdg_pkg::*;

	logic                valid;
	logic                ready;
	logic [LEVEL_W-1:0]  lit_count;
	logic [COLOUR_W-1:0] red_level;
	logic [COLOUR_W-1:0] green_level;

	modport source (output valid, output lit_count, output red_level, output green_level,
		input ready);
	modport sink (input valid, input lit_count, input red_level, input green_level,
		output ready);
endinterface

// ===== design/wsdg_cfg_regs.sv =====
`timescale 1ns / 1ps
module wsdg_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wsdg_pkg::ADDR_W-1:0] paddr,
	input  logic [wsdg_pkg::DATA_W-1:0] pwdata,
	output logic [wsdg_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output wsdg_pkg::cfg_t              cfg
);
	import wsdg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_req;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_req = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_bound      <= LOW_BOUND_RST;
			cfg_q.high_bound     <= HIGH_BOUND_RST;
			cfg_q.spread_ceiling <= SPREAD_CEILING_RST;
			cfg_q.level_count    <= LEVEL_COUNT_RST;
		end else if (wr_req) begin
			unique case (idx)
				REG_LOW_BOUND:      cfg_q.low_bound      <= pwdata[SAMPLE_W-1:0];
				REG_HIGH_BOUND:     cfg_q.high_bound     <= pwdata[SAMPLE_W-1:0];
				REG_SPREAD_CEILING: cfg_q.spread_ceiling <= pwdata[SPREAD_W-1:0];
				REG_LEVEL_COUNT:    cfg_q.level_count    <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (idx)
			REG_LOW_BOUND:      prdata = DATA_W'(cfg_q.low_bound);
			REG_HIGH_BOUND:     prdata = DATA_W'(cfg_q.high_bound);
			REG_SPREAD_CEILING: prdata = DATA_W'(cfg_q.spread_ceiling);
			REG_LEVEL_COUNT:    prdata = DATA_W'(cfg_q.level_count);
			default:            prdata = '0;
		endcase
	end
endmodule

// ===== design/wsdg_ring.sv =====
`timescale 1ns / 1ps
module wsdg_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [wsdg_pkg::WIN_AW-1:0]   rd_addr,
	input  logic                          wr_en,
	input  logic [wsdg_pkg::WIN_AW-1:0]   wr_addr,
	input  logic [wsdg_pkg::SAMPLE_W-1:0] wr_data,
	output logic [wsdg_pkg::SAMPLE_W-1:0] rd_data
);
	import wsdg_pkg::*;

	logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [SAMPLE_W-1:0]     rd_q;
	logic                    rd_valid_q;

	// Sample storage, one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Per-slot valid bits: an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;
endmodule

// ===== design/wsdg_isqrt.sv =====
`timescale 1ns / 1ps
module wsdg_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wsdg_pkg::DEV_W-1:0]  radicand,
	output logic                        done,
	output logic [wsdg_pkg::ROOT_W-1:0] root
);
	import wsdg_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DEV_W-1:0]    x_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    trial;
	logic                ge;

	// One root bit per cycle, two radicand bits consumed
	assign rem_sh = {rem_q[REM_W-3:0], x_q[DEV_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== design/wsdg_div.sv =====
`timescale 1ns / 1ps
module wsdg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wsdg_pkg::DIVD_W-1:0] dividend,
	input  logic [wsdg_pkg::DIVS_W-1:0] divisor,
	output logic                        done,
	output logic [wsdg_pkg::DIVD_W-1:0] quotient
);
	import wsdg_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVS_W-1:0]   den_q;
	logic [DIVS_W:0]     rem_sh;
	logic [DIVS_W:0]     rem_sub;
	logic                ge;

	// Restoring division, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== design/windowed_stddev_led_gauge_core.sv =====
// Sequence: after the accepting edge the sequencer runs the window update, the 16-step square
// root and two 21-step divides on the one shared divider; the level divide is skipped when
// the ceiling is zero and the colour divide when the bounds are not ordered.
// Requests: the next is taken once the result is in the output register, which may still be
// waiting on its sink.
// Reset: arst_n clears the sample ring (per-slot valid bits), sums and slot at once.
`timescale 1ns / 1ps
module windowed_stddev_led_gauge_core (
	input  logic                        clk,
	input  logic                        arst_n,
	wsdg_in_if.sink                     samples,
	wsdg_out_if.source                  readings,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wsdg_pkg::ADDR_W-1:0] paddr,
	input  logic [wsdg_pkg::DATA_W-1:0] pwdata,
	output logic [wsdg_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import wsdg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SQ_OLD,
		ST_SQ_NEW,
		ST_DEV,
		ST_ROOT,
		ST_LIT,
		ST_LIT_WAIT,
		ST_HUE,
		ST_HUE_WAIT,
		ST_DONE
	} state_t;

	localparam logic [WIN_AW-1:0] SLOT_LAST = WIN_AW'(WINDOW_DEPTH - 1);

	state_t               state_q;
	cfg_t                 cfg;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [SAMPLE_W-1:0]  old_q;
	logic [WIN_AW-1:0]    slot_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQSUM_W-1:0]   sqsum_q;
	logic [DEV_W-1:0]     sum_sq_q;
	logic [DIVD_W-1:0]    lit_num_q;
	logic [DIVD_W-1:0]    hue_num_q;
	logic [DIVS_W-1:0]    hue_den_q;
	logic                 hue_low_q;
	logic                 ordered_q;
	logic [LEVEL_W-1:0]   lit_q;
	logic [COLOUR_W-1:0]  red_q;
	logic [COLOUR_W-1:0]  green_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_lit_q;
	logic [COLOUR_W-1:0]  out_red_q;
	logic [COLOUR_W-1:0]  out_green_q;

	logic                 in_req;
	logic [SAMPLE_W-1:0]  ring_rd;
	logic [SAMPLE_W-1:0]  old_val;
	logic [SQ_W-1:0]      old_sq;
	logic [SQ_W-1:0]      new_sq;
	logic [DEV_W-1:0]     sum_sq;
	logic [DEV_W-1:0]     prod;
	logic [DEV_W-1:0]     dev;
	logic                 root_done;
	logic [ROOT_W-1:0]    root;
	logic [SPREAD_W-1:0]  spread;
	logic [SPREAD_W-1:0]  spread_clamp;
	logic [SAMPLE_W-1:0]  clamped;
	logic [SAMPLE_W-1:0]  above_low;
	logic [SAMPLE_W-1:0]  below_high;
	logic                 low_half;
	logic                 div_start;
	logic [DIVD_W-1:0]    div_dividend;
	logic [DIVS_W-1:0]    div_divisor;
	logic                 div_done;
	logic [DIVD_W-1:0]    div_quo;

	wsdg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Ring read at accept, write-back in ST_SQ_OLD after ST_READ; the sequencer keeps them apart
	wsdg_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_req),
		.rd_addr (slot_q),
		.wr_en   (state_q == ST_SQ_OLD),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_data (ring_rd)
	);

	wsdg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DEV),
		.radicand (dev),
		.done     (root_done),
		.root     (root)
	);

	wsdg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign in_req        = samples.valid & samples.ready;

	// Window arithmetic
	assign old_val = ring_rd;
	assign old_sq  = old_q * old_q;
	assign new_sq  = sample_q * sample_q;
	assign sum_sq  = sum_q * sum_q;
	assign prod    = DEV_W'(sqsum_q) * DEV_W'(WINDOW_DEPTH);
	assign dev     = (prod > sum_sq_q) ? prod - sum_sq_q : '0;

	// Spread in whole ms, clamped to the ceiling
	assign spread       = SPREAD_W'(root / SPREAD_DIV);
	assign spread_clamp = (spread > cfg.spread_ceiling) ? cfg.spread_ceiling : spread;

	// Colour gradient position of the newest sample
	always_comb begin
		clamped = sample_q;
		if (clamped < cfg.low_bound) begin
			clamped = cfg.low_bound;
		end
		if (clamped > cfg.high_bound) begin
			clamped = cfg.high_bound;
		end
	end
	assign above_low  = clamped - cfg.low_bound;
	assign below_high = cfg.high_bound - clamped;
	assign low_half   = {above_low, 1'b0} < {1'b0, cfg.high_bound - cfg.low_bound};

	// Shared divider operands
	assign div_start    = ((state_q == ST_LIT) && (cfg.spread_ceiling != '0)) ||
	                      ((state_q == ST_HUE) && ordered_q);
	assign div_dividend = (state_q == ST_LIT) ? lit_num_q : hue_num_q;
	assign div_divisor  = (state_q == ST_LIT) ? DIVS_W'(cfg.spread_ceiling) : hue_den_q;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || readings.ready)) begin
				out_valid_q <= 1'b1;
			end else if (readings.valid && readings.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q   <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
					state_q <= ST_SQ_OLD;
				end
				ST_SQ_OLD: begin
					sqsum_q <= sqsum_q - SQSUM_W'(old_sq);
					slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
					state_q <= ST_SQ_NEW;
				end
				ST_SQ_NEW: begin
					sqsum_q <= sqsum_q + SQSUM_W'(new_sq);
					state_q <= ST_DEV;
				end
				ST_DEV: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_LIT;
					end
				end
				ST_LIT: begin
					if (cfg.spread_ceiling == '0) begin
						state_q <= ST_HUE;
					end else begin
						state_q <= ST_LIT_WAIT;
					end
				end
				ST_LIT_WAIT: begin
					if (div_done) begin
						state_q <= ST_HUE;
					end
				end
				ST_HUE: begin
					if (ordered_q) begin
						state_q <= ST_HUE_WAIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_HUE_WAIT: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || readings.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			sample_q <= samples.hrv_sample;
		end
		if (state_q == ST_READ) begin
			old_q <= old_val;
		end
		if (state_q == ST_SQ_NEW) begin
			sum_sq_q <= sum_sq;
		end
		if (state_q == ST_DEV) begin
			ordered_q <= cfg.high_bound > cfg.low_bound;
			hue_low_q <= low_half;
			hue_den_q <= cfg.high_bound - cfg.low_bound;
			hue_num_q <= DIVD_W'(HUE_SCALE) * DIVD_W'(low_half ? above_low : below_high);
		end
		if ((state_q == ST_ROOT) && root_done) begin
			lit_num_q <= DIVD_W'(spread_clamp) * DIVD_W'(cfg.level_count);
		end
		if (state_q == ST_LIT) begin
			lit_q <= '0;
		end
		if ((state_q == ST_LIT_WAIT) && div_done) begin
			lit_q <= div_quo[LEVEL_W-1:0];
		end
		if ((state_q == ST_HUE) && !ordered_q) begin
			red_q   <= COLOUR_FULL;
			green_q <= COLOUR_NONE;
		end
		if ((state_q == ST_HUE_WAIT) && div_done) begin
			if (hue_low_q) begin
				red_q   <= COLOUR_FULL;
				green_q <= div_quo[COLOUR_W-1:0];
			end else begin
				red_q   <= div_quo[COLOUR_W-1:0];
				green_q <= COLOUR_FULL;
			end
		end
		if ((state_q == ST_DONE) && (!out_valid_q || readings.ready)) begin
			out_lit_q   <= lit_q;
			out_red_q   <= red_q;
			out_green_q <= green_q;
		end
	end

	assign readings.valid       = out_valid_q;
	assign readings.lit_count   = out_lit_q;
	assign readings.red_level   = out_red_q;
	assign readings.green_level = out_green_q;
endmodule
